// ===== hw/rtl/tvnt_pkg.sv =====
package tvnt_pkg;

    // coordinate and tile geometry
    localparam int COORD_W   = 7;
    localparam int TILE_SIZE = 128;

    // lattice hash multipliers
    localparam logic [31:0] HASH_MX = 32'd374761393;
    localparam logic [31:0] HASH_MY = 32'd668265263;
    localparam logic [31:0] HASH_MS = 32'd2246822519;
    localparam logic [31:0] HASH_MF = 32'd1274126177;

    // smoothstep f*f*(768-2f) >> 16
    localparam logic [9:0] SMOOTH_K = 10'd768;

    // divide by 15 as multiply by reciprocal, exact below 4681
    localparam logic [24:0] DIV15_MUL   = 25'd4370;
    localparam int          DIV15_SHIFT = 16;

    localparam logic [7:0] LEVEL_OFFSET = 8'd90;
    localparam logic [9:0] LEVEL_MAX    = 10'd255;

    // configuration register indexes
    localparam logic [7:0] REG_NOISE_SEED = 8'd0;
    localparam logic [7:0] REG_SHARPNESS  = 8'd1;

    localparam int          OCTAVES         = 4;
    localparam logic [5:0]  SHARPNESS_RESET = 6'd16;

endpackage

// ===== hw/rtl/tvnt_octave.sv =====
module tvnt_octave #(
    parameter int CELL_LOG2 = 5
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [tvnt_pkg::COORD_W-1:0]    x,
    input  logic [tvnt_pkg::COORD_W-1:0]    y,
    input  logic [31:0]                     seed_term,
    output logic [7:0]                      value
);

    localparam int CELL   = 1 << CELL_LOG2;
    localparam int N_RAW  = tvnt_pkg::TILE_SIZE / CELL;
    localparam int N_CELL = (N_RAW == 0) ? 1 : N_RAW;
    localparam int IDX_W  = tvnt_pkg::COORD_W - CELL_LOG2;
    localparam int NXT_W  = IDX_W + 1;
    localparam logic [31:0] N_W  = 32'(N_CELL);
    localparam logic [31:0] N2_W = 32'(2 * N_CELL);

    // stage 1: lattice indexes and fractions
    logic [IDX_W-1:0] xi_reg, yi_reg;
    logic [NXT_W-1:0] x1_reg, y1_reg, x1_next, y1_next;
    logic [7:0]       fx1_reg, fy1_reg, fx1_next, fy1_next;

    function automatic logic [NXT_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i) + 32'd1;
        if (w >= N2_W) begin
            w = w - N2_W;
        end else if (w >= N_W) begin
            w = w - N_W;
        end
        return w[NXT_W-1:0];
    endfunction

    always_comb begin
        x1_next  = wrap_next(x[tvnt_pkg::COORD_W-1:CELL_LOG2]);
        y1_next  = wrap_next(y[tvnt_pkg::COORD_W-1:CELL_LOG2]);
        fx1_next = 8'(x[CELL_LOG2-1:0]) << (8 - CELL_LOG2);
        fy1_next = 8'(y[CELL_LOG2-1:0]) << (8 - CELL_LOG2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xi_reg  <= x[tvnt_pkg::COORD_W-1:CELL_LOG2];
            yi_reg  <= y[tvnt_pkg::COORD_W-1:CELL_LOG2];
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            fx1_reg <= fx1_next;
            fy1_reg <= fy1_next;
        end
    end

    // stage 2: hash partial products, fraction squares
    logic [31:0] px0_reg, px1_reg, py0_reg, py1_reg;
    logic [15:0] fxsq_reg, fysq_reg;
    logic [7:0]  fx2_reg, fy2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px0_reg  <= 32'(32'(xi_reg) * tvnt_pkg::HASH_MX);
            px1_reg  <= 32'(32'(x1_reg) * tvnt_pkg::HASH_MX);
            py0_reg  <= 32'(32'(yi_reg) * tvnt_pkg::HASH_MY);
            py1_reg  <= 32'(32'(y1_reg) * tvnt_pkg::HASH_MY);
            fxsq_reg <= 16'(16'(fx1_reg) * 16'(fx1_reg));
            fysq_reg <= 16'(16'(fy1_reg) * 16'(fy1_reg));
            fx2_reg  <= fx1_reg;
            fy2_reg  <= fy1_reg;
        end
    end

    // stage 3: corner hash sums, smoothstep products
    logic [31:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic [25:0] sxp_reg, syp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            h00_reg <= px0_reg + py0_reg + seed_term;
            h10_reg <= px1_reg + py0_reg + seed_term;
            h01_reg <= px0_reg + py1_reg + seed_term;
            h11_reg <= px1_reg + py1_reg + seed_term;
            sxp_reg <= 26'(fxsq_reg) * 26'(tvnt_pkg::SMOOTH_K - {1'b0, fx2_reg, 1'b0});
            syp_reg <= 26'(fysq_reg) * 26'(tvnt_pkg::SMOOTH_K - {1'b0, fy2_reg, 1'b0});
        end
    end

    // stage 4: hash finalize, corner values are the top byte
    function automatic logic [7:0] hash_top(input logic [31:0] h);
        logic [31:0] g;
        logic [31:0] p;
        g = h ^ (h >> 13);
        p = 32'(g * tvnt_pkg::HASH_MF);
        return p[31:24];
    endfunction

    logic [7:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [7:0] sfx_reg, sfy4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg   <= hash_top(h00_reg);
            cb_reg   <= hash_top(h10_reg);
            cc_reg   <= hash_top(h01_reg);
            cd_reg   <= hash_top(h11_reg);
            sfx_reg  <= sxp_reg[23:16];
            sfy4_reg <= syp_reg[23:16];
        end
    end

    // stage 5: horizontal difference products
    logic signed [8:0]  dab, dcd;
    logic signed [17:0] pab_reg, pcd_reg;
    logic [7:0]         ca5_reg, cc5_reg, sfy5_reg;

    always_comb begin
        dab = $signed({1'b0, cb_reg}) - $signed({1'b0, ca_reg});
        dcd = $signed({1'b0, cd_reg}) - $signed({1'b0, cc_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pab_reg  <= dab * $signed({1'b0, sfx_reg});
            pcd_reg  <= dcd * $signed({1'b0, sfx_reg});
            ca5_reg  <= ca_reg;
            cc5_reg  <= cc_reg;
            sfy5_reg <= sfy4_reg;
        end
    end

    // stage 6: horizontal interpolation, arithmetic shift floors
    logic signed [17:0] pab_sh, pcd_sh;
    logic signed [9:0]  top_sum, bot_sum;
    logic [7:0]         top_reg, bot_reg, sfy6_reg;

    always_comb begin
        pab_sh  = pab_reg >>> 8;
        pcd_sh  = pcd_reg >>> 8;
        top_sum = $signed({2'b00, ca5_reg}) + $signed(pab_sh[9:0]);
        bot_sum = $signed({2'b00, cc5_reg}) + $signed(pcd_sh[9:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg  <= top_sum[7:0];
            bot_reg  <= bot_sum[7:0];
            sfy6_reg <= sfy5_reg;
        end
    end

    // stage 7: vertical difference product
    logic signed [8:0]  dtb;
    logic signed [17:0] pv_reg;
    logic [7:0]         top7_reg;

    assign dtb = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            pv_reg   <= dtb * $signed({1'b0, sfy6_reg});
            top7_reg <= top_reg;
        end
    end

    // stage 8: vertical interpolation
    logic signed [17:0] pv_sh;
    logic signed [9:0]  val_sum;
    logic [7:0]         val_reg;

    always_comb begin
        pv_sh   = pv_reg >>> 8;
        val_sum = $signed({2'b00, top7_reg}) + $signed(pv_sh[9:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_sum[7:0];
        end
    end

    assign value = val_reg;

endmodule

// ===== hw/rtl/tileable_value_noise_texel.sv =====
// Tileable four-octave value-noise texel generator.
// Input words on s_t* carry one texel coordinate (col, row); every word gives
// exactly one result word on m_t* holding a 5-bit nebula intensity.
// Registers are written on the cfg_* channel (index 0 noise_seed, index 1
// sharpness); cfg_ready is always high. Write them only while no texel is in
// flight; other indexes are dropped.
// Throughput is one texel per clock while the receiver takes results: all four
// octaves run side by side and every multiply sits in its own pipeline stage.
// A word accepted on s_t* passes these registers in order before it shows on
// m_tvalid: input register, tile wrap, eight octave stages, weighted sum,
// reciprocal multiply for the divide by 15, offset and gain, clamp.
// When the receiver holds m_tready low with a word waiting, the whole pipeline
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and sets noise_seed
// to 0 and sharpness to 16.
module tileable_value_noise_texel (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [6:0] col, [13:7] row

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [4:0] intensity

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int          DEPTH  = 14;
    localparam logic [31:0] TILE_W = 32'(tvnt_pkg::TILE_SIZE);

    logic              adv;
    logic [DEPTH-1:0]  vld_reg;

    // configuration
    logic [15:0] noise_seed_reg;
    logic [5:0]  sharpness_reg;
    logic [31:0] seed_term_reg [tvnt_pkg::OCTAVES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg <= '0;
            sharpness_reg  <= tvnt_pkg::SHARPNESS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == tvnt_pkg::REG_NOISE_SEED) begin
                noise_seed_reg <= cfg_data;
            end else if (cfg_index == tvnt_pkg::REG_SHARPNESS) begin
                sharpness_reg <= cfg_data[5:0];
            end
        end
    end

    // per-octave seed product, follows the seed register
    for (genvar o = 0; o < tvnt_pkg::OCTAVES; o++) begin : g_seed
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                seed_term_reg[o] <= 32'(32'(o) * tvnt_pkg::HASH_MS);
            end else begin
                seed_term_reg[o] <= 32'((32'(noise_seed_reg) + 32'(o)) * tvnt_pkg::HASH_MS);
            end
        end
    end

    // pipeline control: every stage moves together
    assign adv      = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // input register
    logic [6:0] col_reg, row_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            col_reg <= s_tdata[6:0];
            row_reg <= s_tdata[13:7];
        end
    end

    // wrap coordinates into the tile
    function automatic logic [6:0] tile_wrap(input logic [6:0] c);
        logic [31:0] w;
        w = 32'(c);
        for (int k = 0; k < 3; k++) begin
            if (w >= TILE_W) begin
                w = w - TILE_W;
            end
        end
        return w[6:0];
    endfunction

    logic [6:0] x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= tile_wrap(col_reg);
            y_reg <= tile_wrap(row_reg);
        end
    end

    // four octaves, cells 32 down to 4
    logic [7:0] oct_val [tvnt_pkg::OCTAVES];

    for (genvar o = 0; o < tvnt_pkg::OCTAVES; o++) begin : g_oct
        tvnt_octave #(
            .CELL_LOG2 (5 - o)
        ) u_octave (
            .aclk      (aclk),
            .en        (adv),
            .x         (x_reg),
            .y         (y_reg),
            .seed_term (seed_term_reg[o]),
            .value     (oct_val[o])
        );
    end

    // weighted sum 8:4:2:1
    logic [11:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= 12'({oct_val[0], 3'b000}) + 12'({oct_val[1], 2'b00})
                     + 12'({oct_val[2], 1'b0}) + 12'(oct_val[3]);
        end
    end

    // divide by 15 through the reciprocal
    logic [24:0] qp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            qp_reg <= 25'(sum_reg) * tvnt_pkg::DIV15_MUL;
        end
    end

    // offset with floor at zero, then gain
    logic [24:0] q_full;
    logic [7:0]  q_val, q_off;
    logic [13:0] gain_reg;

    always_comb begin
        q_full = qp_reg >> tvnt_pkg::DIV15_SHIFT;
        q_val  = q_full[7:0];
        q_off  = (q_val >= tvnt_pkg::LEVEL_OFFSET) ? q_val - tvnt_pkg::LEVEL_OFFSET : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gain_reg <= 14'(q_off) * 14'(sharpness_reg);
        end
    end

    // clamp and reduce to 5 bits
    logic [9:0] lvl, lvl_clamp;
    logic [4:0] intensity_reg;

    always_comb begin
        lvl       = gain_reg[13:4];
        lvl_clamp = (lvl > tvnt_pkg::LEVEL_MAX) ? tvnt_pkg::LEVEL_MAX : lvl;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            intensity_reg <= lvl_clamp[7:3];
        end
    end

    assign m_tdata = {3'b000, intensity_reg};

endmodule

// ===== sim/tileable_value_noise_texel_tb.sv =====
`timescale 1ns / 1ps

module tileable_value_noise_texel_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TEXELS  = 220;

    typedef struct {
        logic [6:0] col;
        logic [6:0] row;
        logic [4:0] intensity;
    } texel_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // [6:0] col, [13:7] row
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [4:0] intensity
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // local copy of the block's registers
    logic [31:0] seed_reg  = '0;
    logic [5:0]  sharp_reg = tvnt_pkg::SHARPNESS_RESET;

    texel_t intensity_q[$];
    logic   idle_on       = 1'b0;
    int     ready_left    = 0;
    int     cycle_count   = 0;
    int     error_count   = 0;
    int     texels_sent   = 0;
    int     words_checked = 0;
    int     reg_writes    = 0;

    tileable_value_noise_texel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------------------------------------------------------
    // noise predictor

    function automatic logic [7:0] lattice_hash(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] seed);
        logic [31:0] h;
        h = x * tvnt_pkg::HASH_MX + y * tvnt_pkg::HASH_MY + seed * tvnt_pkg::HASH_MS;
        h = (h ^ (h >> 13)) * tvnt_pkg::HASH_MF;
        return h[31:24];
    endfunction

    function automatic int smooth_weight(input int f);
        return (f * f * (int'(tvnt_pkg::SMOOTH_K) - 2 * f)) >> 16;
    endfunction

    // floor division of the product by 256 via arithmetic shift
    function automatic int blend(input int lo, input int hi, input int f);
        return lo + (((hi - lo) * f) >>> 8);
    endfunction

    function automatic int octave_value(input int x, input int y, input int cell_size,
                                        input logic [31:0] seed);
        int n, xi, yi, x1, y1, fx, fy, a, b, c, d;
        n  = tvnt_pkg::TILE_SIZE / cell_size;
        xi = x / cell_size;
        yi = y / cell_size;
        fx = smooth_weight(((x % cell_size) * 256) / cell_size);
        fy = smooth_weight(((y % cell_size) * 256) / cell_size);
        x1 = (xi + 1) % n;
        y1 = (yi + 1) % n;
        a  = lattice_hash(xi, yi, seed);
        b  = lattice_hash(x1, yi, seed);
        c  = lattice_hash(xi, y1, seed);
        d  = lattice_hash(x1, y1, seed);
        return blend(blend(a, b, fx), blend(c, d, fx), fy);
    endfunction

    function automatic logic [4:0] texel_intensity(input logic [6:0] col, input logic [6:0] row);
        int x, y, v;
        x = col % tvnt_pkg::TILE_SIZE;
        y = row % tvnt_pkg::TILE_SIZE;
        v = octave_value(x, y, 32, seed_reg) * 8
          + octave_value(x, y, 16, seed_reg + 1) * 4
          + octave_value(x, y, 8, seed_reg + 2) * 2
          + octave_value(x, y, 4, seed_reg + 3);
        if (v < 0) v = 0;
        v = v / 15;
        v = v - int'(tvnt_pkg::LEVEL_OFFSET);
        if (v < 0) v = 0;
        v = (v * int'(sharp_reg)) >>> 4;
        if (v > int'(tvnt_pkg::LEVEL_MAX)) v = int'(tvnt_pkg::LEVEL_MAX);
        return v[7:3];
    endfunction

    // ---------------------------------------------------------------
    // checking

    task automatic report_mismatch(input string what, input texel_t want, input logic [4:0] got);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] %s: col %0d row %0d intensity got %0d want %0d",
                     $realtime, what, want.col, want.row, got, want.intensity);
    endtask

    always @(posedge aclk) begin : word_monitor
        texel_t want;
        texel_t none;
        none = '{col: '0, row: '0, intensity: '0};
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (intensity_q.size() == 0) begin
                    report_mismatch("unexpected word", none, m_tdata[4:0]);
                end else begin
                    want = intensity_q.pop_front();
                    words_checked++;
                    if (m_tdata[4:0] !== want.intensity)
                        report_mismatch("intensity mismatch", want, m_tdata[4:0]);
                end
            end
            if (s_tvalid && s_tready) begin
                want.col = s_tdata[6:0];
                want.row = s_tdata[13:7];
                want.intensity = texel_intensity(want.col, want.row);
                intensity_q.push_back(want);
            end
        end
    end

    // ---------------------------------------------------------------
    // idling on both sides

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready   <= 1'b1;
            ready_left <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_left <= pick_gap();
        end else begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, 12);
        end
    end

    // ---------------------------------------------------------------
    // drivers

    task automatic send_texel(input logic [6:0] col, input logic [6:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        texels_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (intensity_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == tvnt_pkg::REG_NOISE_SEED)
            seed_reg = {16'h0000, data};
        else if (idx == tvnt_pkg::REG_SHARPNESS)
            sharp_reg = data[5:0];
        reg_writes++;
        @(posedge aclk);
    endtask

    // biased toward tile edges and cell borders
    function automatic logic [6:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'd127;
        if (r == 2) return 7'($urandom_range(0, 31) * 4 + $urandom_range(0, 1) * 3);
        return 7'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // tests

    task automatic test_corner_texels();
        send_texel(7'd0, 7'd0);
        send_texel(7'd127, 7'd127);
        send_texel(7'd127, 7'd0);
        send_texel(7'd0, 7'd127);
        send_texel(7'd31, 7'd32);
        send_texel(7'd32, 7'd31);
        send_texel(7'd63, 7'd64);
        send_texel(7'd95, 7'd96);
        send_texel(7'd3, 7'd4);
        send_texel(7'd4, 7'd3);
        send_texel(7'd85, 7'd42);
        send_texel(7'd126, 7'd1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        // upper data bits of sharpness must be dropped
        write_reg(tvnt_pkg::REG_NOISE_SEED, 16'hFFFF);
        write_reg(tvnt_pkg::REG_SHARPNESS, 16'hFFFF);
        send_texel(7'd0, 7'd0);
        send_texel(7'd127, 7'd127);
        send_texel(7'd64, 7'd17);
        send_texel(7'd42, 7'd85);
        drain_results();
        write_reg(tvnt_pkg::REG_SHARPNESS, 16'hFFC0);
        send_texel(7'd10, 7'd100);
        send_texel(7'd127, 7'd0);
        drain_results();
        // writes to unknown indexes leave both registers alone
        write_reg(tvnt_pkg::REG_SHARPNESS, 16'h0001);
        write_reg(8'hFF, 16'h0000);
        write_reg(8'hFE, 16'h1234);
        write_reg(8'd2, 16'hFFFF);
        send_texel(7'd5, 7'd7);
        send_texel(7'd120, 7'd60);
        send_texel(7'd33, 7'd99);
        drain_results();
        write_reg(tvnt_pkg::REG_NOISE_SEED, 16'h0000);
        write_reg(tvnt_pkg::REG_SHARPNESS, 16'd16);
        send_texel(7'd1, 7'd126);
        send_texel(7'd77, 7'd12);
        drain_results();
    endtask

    task automatic test_random_texels();
        logic [15:0] seed;
        logic [5:0]  sharp;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin seed = 16'h0000; sharp = 6'd16; end
                1: begin seed = 16'hFFFF; sharp = 6'd63; end
                2: begin seed = 16'($urandom); sharp = 6'd0; end
                3: begin seed = 16'($urandom); sharp = 6'd32; end
                default: begin seed = 16'($urandom); sharp = 6'($urandom_range(1, 63)); end
            endcase
            if (phase % 2 == 1)
                write_reg(8'($urandom_range(2, 255)), 16'($urandom));
            write_reg(tvnt_pkg::REG_NOISE_SEED, seed);
            write_reg(tvnt_pkg::REG_SHARPNESS, {10'($urandom), sharp});
            idle_on <= (phase % 4 != 0);
            // phase 2 has zero gain, so keep it short
            for (int i = 0; i < ((phase == 2) ? 40 : PHASE_TEXELS); i++)
                send_texel(pick_coord(), pick_coord());
            drain_results();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_texels();
        test_register_extremes();
        test_random_texels();
        drain_results();
        repeat (20) @(posedge aclk);
        $display("sent %0d texels, checked %0d result words", texels_sent, words_checked);
        $display("register writes %0d, including unknown indexes and gain extremes", reg_writes);
        if (error_count == 0 && intensity_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count, intensity_q.size());
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

endmodule
